@@ rtl/box_mean_filter_3x3_macros.svh @@
// Assertion macros shared by the box mean filter RTL
`ifndef BOX_MEAN_FILTER_3X3_MACROS_SVH
`define BOX_MEAN_FILTER_3X3_MACROS_SVH

// Same-cycle implication, checked outside reset; expects clk and rst in scope
`define BMF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset; expects clk and rst in scope
`define BMF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/bmf_pkg.sv @@
// Types, constants and helper functions of the box mean filter
`timescale 1ns / 1ps

package bmf_pkg;

  // Neighbourhood sum of up to nine 8-bit pixels
  localparam int SUM_W   = 12;
  localparam int RECIP_W = 15;
  localparam int SHIFT   = 16;
  localparam int PROD_W  = SUM_W + RECIP_W;

  localparam logic [RECIP_W-1:0] RECIP_4 = 15'd16384;
  localparam logic [RECIP_W-1:0] RECIP_6 = 15'd10923;
  localparam logic [RECIP_W-1:0] RECIP_9 = 15'd7282;

  typedef enum logic [1:0] {
    DIV_4,
    DIV_6,
    DIV_9
  } div_sel_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_PUSH
  } bmf_state_t;

  // Control that travels with each pixel read into the accumulator
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } acc_ctl_t;

  // Reciprocal scaled by 2**SHIFT, exact for sums below 2**15
  function automatic logic [RECIP_W-1:0] recip(input div_sel_t sel);
    logic [RECIP_W-1:0] r;
    case (sel)
      DIV_4:   r = RECIP_4;
      DIV_6:   r = RECIP_6;
      DIV_9:   r = RECIP_9;
      default: r = RECIP_9;
    endcase
    return r;
  endfunction

  // Ring slot of a row lying back rows behind the row in slot s
  function automatic logic [1:0] slot_back(input logic [1:0] s, input logic [1:0] back);
    logic [1:0] r;
    case ({s, back})
      4'b00_00: r = 2'd0;
      4'b00_01: r = 2'd2;
      4'b00_10: r = 2'd1;
      4'b01_00: r = 2'd1;
      4'b01_01: r = 2'd0;
      4'b01_10: r = 2'd2;
      4'b10_00: r = 2'd2;
      4'b10_01: r = 2'd1;
      4'b10_10: r = 2'd0;
      default:  r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/bmf_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read
`timescale 1ns / 1ps

module bmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/bmf_mean.sv @@
// Neighbourhood accumulator and divide-by-4/6/9 unit
`timescale 1ns / 1ps

module bmf_mean (
  input  logic               clk,
  input  logic               rst,
  input  bmf_pkg::acc_ctl_t  ctl,
  input  logic [7:0]         pix,
  input  bmf_pkg::div_sel_t  div,
  output logic               mean_valid,
  output logic [7:0]         mean
);
  import bmf_pkg::*;

  logic [SUM_W-1:0]  sum;
  logic              sum_done;
  div_sel_t          div_hold;
  logic [PROD_W-1:0] prod;
  logic              prod_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_done   <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      sum_done   <= ctl.valid && ctl.last;
      prod_valid <= sum_done;
    end
  end

  // Accumulate; restart on the first pixel of a neighbourhood
  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      sum <= (ctl.first ? '0 : sum) + SUM_W'(pix);
      if (ctl.last) begin
        div_hold <= div;
      end
    end
    if (sum_done) begin
      prod <= PROD_W'(sum) * PROD_W'(recip(div_hold));
    end
  end

  assign mean_valid = prod_valid;
  assign mean       = prod[SHIFT+7:SHIFT];

endmodule

@@ rtl/box_mean_filter_3x3.sv @@
// Top level of the 3x3 box mean filter with border shrink
`timescale 1ns / 1ps

// Usage
//   s_* : pixel beats in raster order; tdata[7:0] = pixel.
//   m_* : smoothed pixel beats; tdata = {mean, col, row}, tlast closes the
//         results caused by one input pixel, tuser marks the bottom-right pixel.
//   cfg_we/cfg_wdata : frame side (2..MAX_DIM, clamped); a write restarts the
//         frame. Write only while idle.
// Pixel (r,c) of the frame yields result (r-1,c-1), plus (r-1,last col) at a
// row end, plus the whole last row on the final pixel. First row and column
// pixels yield nothing.
// Flow: a pixel beat is taken only in IDLE. Each result then takes k = 4, 6
// or 9 neighbourhood reads, one per cycle through the single read port of the
// row store, then passes the accumulator and the reciprocal multiplier and is
// pushed. The next pixel is taken once every result of the previous one sits
// in the output register.
// Reset clears counters and handshakes and sets the side to 2; the row store
// holds no reset and is only read where the current frame has written it.
// A stalled receiver holds the output register; the block waits in PUSH.
module box_mean_filter_3x3 #(
  parameter int MAX_DIM = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,   // frame_side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,     // [7:0] pixel_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,     // [3:0] out_row, [7:4] out_col, [15:8] mean_value
  output logic        m_tlast,     // last_of_run
  output logic        m_tuser      // [0] last_of_frame
);
  import bmf_pkg::*;

  `include "box_mean_filter_3x3_macros.svh"

  localparam int CW    = $clog2(MAX_DIM);
  localparam int NW    = $clog2(MAX_DIM + 1);
  localparam int DEPTH = 3 * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);

  bmf_state_t state, state_next;

  logic [4:0]    frame_side;
  logic [NW-1:0] side;
  logic [CW-1:0] nm1;

  // Position of the next input pixel and its ring slot
  logic [CW-1:0] row_count, col_count;
  logic [1:0]    row_slot;

  // Accepted pixel
  logic [CW-1:0] px_row, px_col;
  logic [1:0]    px_slot;

  // Result being worked on
  logic [CW-1:0] job_row, job_col;
  logic          job_sweep;

  // Neighbourhood read walk
  logic          rd_first;
  logic [CW-1:0] rd_row, rd_col;
  acc_ctl_t      rd_data_ctl;

  logic [7:0]    mean_hold;

  logic          out_valid, out_last, out_lastf;
  logic [3:0]    out_row, out_col;
  logic [7:0]    out_mean;

  logic          s_acc, rd_go, push_go;

  // ---------------------------------------------------------------- side
  always_comb begin
    if (frame_side < 5'd2) begin
      side = NW'(2);
    end else if (8'(frame_side) > 8'(MAX_DIM)) begin
      side = NW'(MAX_DIM);
    end else begin
      side = NW'(frame_side);
    end
  end
  assign nm1 = CW'(side - NW'(1));

  // ---------------------------------------------------------------- input position
  logic          pos_oor;
  logic [CW-1:0] pos_row, pos_col;
  logic [1:0]    pos_slot;
  logic          pos_has_job;

  assign pos_oor     = (NW'(row_count) >= side) || (NW'(col_count) >= side);
  assign pos_row     = pos_oor ? '0 : row_count;
  assign pos_col     = pos_oor ? '0 : col_count;
  assign pos_slot    = pos_oor ? 2'd0 : row_slot;
  assign pos_has_job = (pos_row != '0) && (pos_col != '0);

  assign s_acc = s_tvalid && s_tready;

  // ---------------------------------------------------------------- job bounds
  logic          j_top, j_bot, j_left, j_right;
  logic [CW-1:0] rlo, rhi, clo, chi;
  div_sel_t      div_sel;

  assign j_top   = (job_row == '0);
  assign j_bot   = (job_row == nm1);
  assign j_left  = (job_col == '0);
  assign j_right = (job_col == nm1);
  assign rlo = j_top   ? job_row : job_row - CW'(1);
  assign rhi = j_bot   ? job_row : job_row + CW'(1);
  assign clo = j_left  ? job_col : job_col - CW'(1);
  assign chi = j_right ? job_col : job_col + CW'(1);

  always_comb begin
    if ((j_top || j_bot) && (j_left || j_right)) begin
      div_sel = DIV_4;
    end else if (j_top || j_bot || j_left || j_right) begin
      div_sel = DIV_6;
    end else begin
      div_sel = DIV_9;
    end
  end

  // Next result of this pixel: row-end column, then the last-row sweep
  logic nx_end, nx_sweep, nx_more, has_next;
  assign nx_end   = !job_sweep && (px_col == nm1) && !j_right;
  assign nx_sweep = !job_sweep && (px_col == nm1) && (px_row == nm1) && j_right;
  assign nx_more  = job_sweep && !j_right;
  assign has_next = nx_end || nx_sweep || nx_more;

  // ---------------------------------------------------------------- read walk
  logic [CW-1:0] cur_rr, cur_cc;
  logic          rd_last;
  logic [CW:0]   row_diff;
  logic [1:0]    rd_slot;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [7:0]    rd_pix;

  assign cur_rr   = rd_first ? rlo : rd_row;
  assign cur_cc   = rd_first ? clo : rd_col;
  assign rd_last  = (cur_rr == rhi) && (cur_cc == chi);
  assign row_diff = {1'b0, px_row} - {1'b0, cur_rr};
  assign rd_slot  = slot_back(px_slot, row_diff[1:0]);
  assign rd_addr  = AW'(rd_slot) * AW'(MAX_DIM) + AW'(cur_cc);
  assign wr_addr  = AW'(pos_slot) * AW'(MAX_DIM) + AW'(pos_col);

  bmf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_row_store (
    .clk   (clk),
    .we    (s_acc),
    .waddr (wr_addr),
    .wdata (s_tdata),
    .raddr (rd_addr),
    .rdata (rd_pix)
  );

  logic       mean_valid;
  logic [7:0] mean;

  bmf_mean u_mean (
    .clk        (clk),
    .rst        (rst),
    .ctl        (rd_data_ctl),
    .pix        (rd_pix),
    .div        (div_sel),
    .mean_valid (mean_valid),
    .mean       (mean)
  );

  // ---------------------------------------------------------------- FSM
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!cfg_we && s_acc && pos_has_job) state_next = ST_READ;
      end
      ST_READ: begin
        if (rd_last) state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (mean_valid) state_next = ST_PUSH;
      end
      ST_PUSH: begin
        if (push_go) state_next = has_next ? ST_READ : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    rd_go    = 1'b0;
    push_go  = 1'b0;
    case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_READ: rd_go    = 1'b1;
      ST_WAIT: ;
      ST_PUSH: push_go  = !out_valid || m_tready;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      frame_side  <= 5'd2;
      row_count   <= '0;
      col_count   <= '0;
      row_slot    <= 2'd0;
      rd_data_ctl <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      rd_data_ctl <= '{valid: rd_go, first: rd_first, last: rd_last};
      if (cfg_we) begin
        // restart the frame on any side write
        frame_side <= cfg_wdata;
        row_count  <= '0;
        col_count  <= '0;
        row_slot   <= 2'd0;
      end else if (s_acc) begin
        if (pos_col == nm1) begin
          col_count <= '0;
          if (pos_row == nm1) begin
            row_count <= '0;
            row_slot  <= 2'd0;
          end else begin
            row_count <= pos_row + CW'(1);
            row_slot  <= (pos_slot == 2'd2) ? 2'd0 : pos_slot + 2'd1;
          end
        end else begin
          row_count <= pos_row;
          col_count <= pos_col + CW'(1);
          row_slot  <= pos_slot;
        end
      end
      if (push_go) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- datapath registers
  always_ff @(posedge clk) begin
    if (s_acc) begin
      px_row    <= pos_row;
      px_col    <= pos_col;
      px_slot   <= pos_slot;
      job_row   <= pos_row - CW'(1);
      job_col   <= pos_col - CW'(1);
      job_sweep <= 1'b0;
      rd_first  <= 1'b1;
    end
    if (rd_go) begin
      rd_first <= 1'b0;
      if (cur_cc == chi) begin
        rd_col <= clo;
        rd_row <= cur_rr + CW'(1);
      end else begin
        rd_col <= cur_cc + CW'(1);
        rd_row <= cur_rr;
      end
    end
    if (mean_valid) begin
      mean_hold <= mean;
    end
    if (push_go) begin
      out_row   <= 4'(job_row);
      out_col   <= 4'(job_col);
      out_mean  <= mean_hold;
      out_last  <= !has_next;
      out_lastf <= job_sweep && j_right;
      rd_first  <= 1'b1;
      // advance to the next result of this pixel
      if (nx_end) begin
        job_col <= nm1;
      end else if (nx_sweep) begin
        job_row   <= nm1;
        job_col   <= '0;
        job_sweep <= 1'b1;
      end else if (nx_more) begin
        job_col <= job_col + CW'(1);
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_mean, out_col, out_row};
  assign m_tlast  = out_last;
  assign m_tuser  = out_lastf;

  // ---------------------------------------------------------------- assertions
  `BMF_ASSERT_IMP(a_mean_in_wait, mean_valid, state == ST_WAIT, "mean ready outside wait")
  `BMF_ASSERT_NXT(a_mean_to_push, mean_valid, state == ST_PUSH, "mean not pushed")
  `BMF_ASSERT_IMP(a_no_read_in_push, state == ST_PUSH, !rd_data_ctl.valid, "read at push")
  `BMF_ASSERT_IMP(a_frame_end_closes, m_tvalid && m_tuser, m_tlast, "frame end not run end")

endmodule
